>>> rtl/transparency_run_length_encoder_top_macros.svh
// Assertion macros shared by the encoder RTL.
// Depends on nothing; the using module must have clk and arst_n in scope.
`ifndef TRANSPARENCY_RUN_LENGTH_ENCODER_TOP_MACROS_SVH
`define TRANSPARENCY_RUN_LENGTH_ENCODER_TOP_MACROS_SVH

// A property that must hold at every rising clock edge out of reset.
`define TRLE_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// A condition that must never be seen out of reset.
`define TRLE_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`endif

>>> rtl/trle_pkg.sv
// Shared types and constants of the transparency run-length encoder.
// Depends on nothing; used by every module of the block.
`default_nettype none

package trle_pkg;

	// Longest run that one beat can report.
	localparam logic [7:0] MAX_RUN = 8'd255;

	// Configuration register indexes and reset values.
	localparam int unsigned CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_TRANSPARENCY_KEY = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_KEY_FROM_FIRST = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_BYTE_LIMIT = 2'd2;
	localparam logic [15:0] BYTE_LIMIT_RESET = 16'd20000;

	// One input beat: a pixel with its row and image marks.
	typedef struct packed {
		logic [7:0] pixel;
		logic row_end;
		logic image_end;
	} in_beat_t;

	// One output beat: a closed run.
	typedef struct packed {
		logic is_transparent;
		logic [7:0] run_length;
		logic [15:0] total_bytes;
		logic overflow;
		logic last;
	} out_beat_t;

	// Configuration register contents.
	typedef struct packed {
		logic [7:0] transparency_key;
		logic key_from_first_pixel;
		logic [15:0] byte_limit;
	} cfg_t;

	// Up to two runs closed by one pixel, oldest first.
	typedef struct packed {
		logic v0;
		logic v1;
		out_beat_t r0;
		out_beat_t r1;
	} push_t;

endpackage

`default_nettype wire

>>> rtl/transparency_run_length_encoder_top.sv
// Top level of the transparency run-length encoder: configuration registers
// and the connection of trle_core and trle_out_buf. Depends on trle_pkg.
//
// The encoder takes one palette pixel per cycle in raster order, unless
// stalled, and emits one beat per closed run (kind, length, running byte
// total, overflow, last). A pixel waits in an input register while its runs
// are formed, and they are registered into the result buffer once it has
// room; its beats are then read out of that buffer. Throughput is one pixel
// per cycle while the output is not stalled. A pixel that closes two runs
// (class change and then row end, image end or a full run) holds the input
// while both runs wait, since the output channel carries one run per beat
// out of a two-entry result buffer. While the output is stalled, a waiting
// run also holds the input. Configuration is written through cfg_we,
// cfg_index and cfg_data while the block is idle, which the user must ensure
// as the block does not enforce it; byte_limit resets to 20000.
`default_nettype none

module transparency_run_length_encoder_top (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic cfg_we,
	input  wire logic [trle_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [15:0] cfg_data,
	input  wire logic pix_valid,
	output logic pix_stall,
	input  wire trle_pkg::in_beat_t pix,
	output logic run_valid,
	input  wire logic run_stall,
	output trle_pkg::out_beat_t run
);

	trle_pkg::cfg_t cfg_q;
	trle_pkg::push_t push;
	logic can_take;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.transparency_key <= 8'd0;
			cfg_q.key_from_first_pixel <= 1'b0;
			cfg_q.byte_limit <= trle_pkg::BYTE_LIMIT_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				trle_pkg::CFG_TRANSPARENCY_KEY: begin
					cfg_q.transparency_key <= cfg_data[7:0];
				end
				trle_pkg::CFG_KEY_FROM_FIRST: begin
					cfg_q.key_from_first_pixel <= cfg_data[0];
				end
				trle_pkg::CFG_BYTE_LIMIT: begin
					cfg_q.byte_limit <= cfg_data;
				end
				default: begin
					cfg_q <= cfg_q;
				end
			endcase
		end
	end

	// Run classification and closing.
	trle_core u_core (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_q),
		.pix_valid(pix_valid),
		.pix_stall(pix_stall),
		.pix(pix),
		.can_take(can_take),
		.push(push)
	);

	// Result buffer toward the output channel.
	trle_out_buf u_out_buf (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.can_take(can_take),
		.run_valid(run_valid),
		.run_stall(run_stall),
		.run(run)
	);

endmodule

`default_nettype wire

>>> rtl/trle_core.sv
// Pixel input register, run state and run closing logic.
// Depends on trle_pkg and the assertion macro header.
`default_nettype none
`include "transparency_run_length_encoder_top_macros.svh"

module trle_core (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire trle_pkg::cfg_t cfg,
	input  wire logic pix_valid,
	output logic pix_stall,
	input  wire trle_pkg::in_beat_t pix,
	input  wire logic can_take,
	output trle_pkg::push_t push
);

	logic valid_s1;
	trle_pkg::in_beat_t pix_s1;

	logic [7:0] run_count_q;
	logic run_class_q;
	logic [15:0] byte_total_q;
	logic overflowed_q;
	logic [7:0] latched_key_q;
	logic at_image_start_q;

	logic fire;
	logic [7:0] key_next;
	logic [7:0] active_key;
	logic cls;
	logic close0;
	logic emit0;
	logic [15:0] total1;
	logic ovf1;
	logic [16:0] sum1;
	logic [7:0] count_after;
	logic close1;
	logic emit1;
	logic [15:0] total2;
	logic ovf2;
	logic [16:0] sum2;

	// The input register takes a beat whenever it is empty or moving on.
	assign pix_stall = valid_s1 && !can_take;
	assign fire = valid_s1 && can_take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!pix_stall) begin
			valid_s1 <= pix_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (pix_valid && !pix_stall) begin
			pix_s1 <= pix;
		end
	end

	// Classify the pixel and close at most two runs.
	always_comb begin
		key_next = (at_image_start_q && cfg.key_from_first_pixel) ? pix_s1.pixel
			: latched_key_q;
		active_key = cfg.key_from_first_pixel ? key_next : cfg.transparency_key;
		cls = (pix_s1.pixel == active_key);

		// A class change closes the run in progress; it is never the image's last.
		close0 = (run_count_q != 8'd0) && (cls != run_class_q);
		emit0 = close0 && !overflowed_q;
		sum1 = {1'b0, byte_total_q} + 17'd2;
		total1 = byte_total_q;
		ovf1 = overflowed_q;
		if (emit0) begin
			total1 = sum1[16] ? 16'hFFFF : sum1[15:0];
			ovf1 = (total1 >= cfg.byte_limit);
		end

		// The pixel's own run closes on length, row end or image end.
		count_after = close0 ? 8'd1 : 8'(run_count_q + 8'd1);
		close1 = (count_after >= trle_pkg::MAX_RUN) || pix_s1.row_end
			|| pix_s1.image_end;
		emit1 = close1 && (!ovf1 || pix_s1.image_end);
		sum2 = {1'b0, total1} + 17'd2;
		total2 = total1;
		ovf2 = ovf1;
		if (close1 && !ovf1) begin
			total2 = sum2[16] ? 16'hFFFF : sum2[15:0];
			ovf2 = (total2 >= cfg.byte_limit);
		end

		push.v0 = fire && emit0;
		push.v1 = fire && emit1;
		push.r0.is_transparent = run_class_q;
		push.r0.run_length = run_count_q;
		push.r0.total_bytes = total1;
		push.r0.overflow = ovf1;
		push.r0.last = 1'b0;
		push.r1.is_transparent = cls;
		push.r1.run_length = count_after;
		push.r1.total_bytes = total2;
		push.r1.overflow = ovf2;
		push.r1.last = pix_s1.image_end;
	end

	// Run state advances once per processed pixel and clears at image end.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_count_q <= 8'd0;
			run_class_q <= 1'b0;
			byte_total_q <= 16'd0;
			overflowed_q <= 1'b0;
			latched_key_q <= 8'd0;
			at_image_start_q <= 1'b1;
		end else if (fire) begin
			latched_key_q <= key_next;
			at_image_start_q <= pix_s1.image_end;
			if (pix_s1.image_end) begin
				run_count_q <= 8'd0;
				run_class_q <= 1'b0;
				byte_total_q <= 16'd0;
				overflowed_q <= 1'b0;
			end else begin
				run_count_q <= close1 ? 8'd0 : count_after;
				run_class_q <= cls;
				byte_total_q <= total2;
				overflowed_q <= ovf2;
			end
		end
	end

	`TRLE_NEVER(a_run_below_max, run_count_q == trle_pkg::MAX_RUN, "open run reached MAX_RUN")
	`TRLE_ASSERT(a_start_clean,
		at_image_start_q |-> (run_count_q == 8'd0 && byte_total_q == 16'd0
			&& !overflowed_q),
		"image start with stale run state")
	`TRLE_ASSERT(a_pair_changes_class,
		(push.v0 && push.v1) |-> (push.r0.is_transparent != push.r1.is_transparent),
		"two runs of one pixel share a class")
	`TRLE_NEVER(a_first_not_last, push.v0 && push.r0.last, "class change run marked last")

endmodule

`default_nettype wire

>>> rtl/trle_out_buf.sv
// Two-entry result buffer between the run logic and the output channel.
// Depends on trle_pkg and the assertion macro header.
`default_nettype none
`include "transparency_run_length_encoder_top_macros.svh"

module trle_out_buf (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire trle_pkg::push_t push,
	output logic can_take,
	output logic run_valid,
	input  wire logic run_stall,
	output trle_pkg::out_beat_t run
);

	logic va_q;
	logic vb_q;
	trle_pkg::out_beat_t a_q;
	trle_pkg::out_beat_t b_q;
	logic pop;
	logic push_any;

	// Room for a full pair when empty, or once the head beat leaves, if it is alone.
	assign pop = va_q && !run_stall;
	assign can_take = !va_q || (!vb_q && pop);
	assign push_any = push.v0 || push.v1;

	assign run_valid = va_q;
	assign run = a_q;

	// Slot A is the head; slot B moves up after each beat taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			va_q <= 1'b0;
			vb_q <= 1'b0;
		end else if (push_any) begin
			va_q <= 1'b1;
			vb_q <= push.v0 && push.v1;
		end else if (pop) begin
			va_q <= vb_q;
			vb_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push_any) begin
			a_q <= push.v0 ? push.r0 : push.r1;
			b_q <= push.r1;
		end else if (pop) begin
			a_q <= b_q;
		end
	end

	`TRLE_ASSERT(a_b_needs_a, vb_q |-> va_q, "second slot filled without head")
	`TRLE_ASSERT(a_push_has_room, push_any |-> can_take, "runs pushed without room")
	`TRLE_ASSERT(a_pair_moves_up, (pop && vb_q && !push_any) |=> (va_q && !vb_q), "second beat lost after pop")

endmodule

`default_nettype wire

>>> sim/tb_transparency_run_length_encoder_top.sv
// Self-checking testbench for transparency_run_length_encoder_top.
// Depends on trle_pkg and the encoder RTL. A local run predictor follows each
// accepted pixel beat, and every run beat is compared against its prediction.

module tb_transparency_run_length_encoder_top;

	localparam int HOLD_CYCLES = 80;
	localparam int DRAIN_CYCLES = 8;
	localparam int MAX_PRINTED = 40;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [trle_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [15:0] cfg_data = '0;
	logic pix_valid = 1'b0;
	logic pix_stall;
	trle_pkg::in_beat_t pix = '0;
	logic run_valid;
	logic run_stall = 1'b0;
	trle_pkg::out_beat_t run;

	transparency_run_length_encoder_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.pix_valid(pix_valid),
		.pix_stall(pix_stall),
		.pix(pix),
		.run_valid(run_valid),
		.run_stall(run_stall),
		.run(run)
	);

	// Shadow of the configuration registers.
	logic [7:0] cfg_key = 8'd0;
	logic cfg_from_first = 1'b0;
	logic [15:0] cfg_limit = trle_pkg::BYTE_LIMIT_RESET;

	// Shadow of the encoder's run and image state.
	logic [7:0] run_count = 8'd0;
	logic run_class = 1'b0;
	logic [15:0] byte_total = 16'd0;
	logic img_overflowed = 1'b0;
	logic [7:0] latched_key = 8'd0;
	logic at_image_start = 1'b1;

	trle_pkg::in_beat_t pending_pixels[$];
	trle_pkg::out_beat_t expected_runs[$];
	int mismatch_count = 0;

	// Handshake bookkeeping and idling control shared between processes.
	bit pix_taken = 1'b0;
	bit quiet = 1'b0;
	bit steady_sender = 1'b0;
	bit hold_request = 1'b0;
	int hold_left = 0;

	initial begin
		forever #10 clk = ~clk;
	end

	initial begin
		#2000000;
		$display("tb_transparency_run_length_encoder_top NOT OK");
		$finish;
	end

	task automatic report_mismatch(input string what);
		mismatch_count++;
		if (mismatch_count <= MAX_PRINTED) begin
			$display("mismatch at %0t: %s", $time, what);
		end
	endtask

	// Closes one run: accounts its two bytes and queues the beat unless the
	// image has already overflowed and this is not its final run.
	task automatic close_run(input logic cls, input logic [7:0] len, input logic is_last);
		logic [16:0] sum;
		trle_pkg::out_beat_t r;
		if (img_overflowed && !is_last) begin
			return;
		end
		if (!img_overflowed) begin
			sum = {1'b0, byte_total} + 17'd2;
			byte_total = (sum > 17'd65535) ? 16'hFFFF : sum[15:0];
			if (byte_total >= cfg_limit) begin
				img_overflowed = 1'b1;
			end
		end
		r.is_transparent = cls;
		r.run_length = len;
		r.total_bytes = byte_total;
		r.overflow = img_overflowed;
		r.last = is_last;
		expected_runs.push_back(r);
	endtask

	// Predicts the runs closed by one accepted pixel beat.
	task automatic encode_pixel(input trle_pkg::in_beat_t b);
		logic [7:0] key;
		logic cls;
		if (at_image_start && cfg_from_first) begin
			latched_key = b.pixel;
		end
		at_image_start = 1'b0;
		key = cfg_from_first ? latched_key : cfg_key;
		cls = (b.pixel == key);
		// A class change closes the old run first.
		if (run_count != 0 && cls != run_class) begin
			close_run(run_class, run_count, 1'b0);
			run_count = 8'd0;
		end
		run_class = cls;
		run_count = run_count + 8'd1;
		if (run_count >= trle_pkg::MAX_RUN || b.row_end || b.image_end) begin
			close_run(run_class, run_count, b.image_end);
			run_count = 8'd0;
		end
		if (b.image_end) begin
			run_count = 8'd0;
			run_class = 1'b0;
			byte_total = 16'd0;
			img_overflowed = 1'b0;
			at_image_start = 1'b1;
		end
	endtask

	task automatic check_run(input trle_pkg::out_beat_t got);
		trle_pkg::out_beat_t want;
		if (expected_runs.size() == 0) begin
			report_mismatch($sformatf("run beat %h with nothing expected", got));
			return;
		end
		want = expected_runs.pop_front();
		if (got.is_transparent !== want.is_transparent)
			report_mismatch($sformatf("is_transparent %b, expected %b",
				got.is_transparent, want.is_transparent));
		if (got.run_length !== want.run_length)
			report_mismatch($sformatf("run_length %0d, expected %0d",
				got.run_length, want.run_length));
		if (got.total_bytes !== want.total_bytes)
			report_mismatch($sformatf("total_bytes %0d, expected %0d",
				got.total_bytes, want.total_bytes));
		if (got.overflow !== want.overflow)
			report_mismatch($sformatf("overflow %b, expected %b", got.overflow, want.overflow));
		if (got.last !== want.last)
			report_mismatch($sformatf("last %b, expected %b", got.last, want.last));
	endtask

	// Monitor: both channels are sampled at the rising edge.
	always @(posedge clk) begin
		if (arst_n) begin
			if (run_valid && !run_stall) begin
				check_run(run);
			end
			if (pix_valid && !pix_stall) begin
				encode_pixel(pix);
				pix_taken = 1'b1;
			end
		end
	end

	// Driver: a new pixel beat is offered only once the previous one is taken.
	always @(negedge clk) begin
		if (arst_n && (!pix_valid || pix_taken)) begin
			pix_taken = 1'b0;
			if (pending_pixels.size() != 0 &&
					(quiet || steady_sender || $urandom_range(0, 99) >= 27)) begin
				pix_valid <= 1'b1;
				pix <= pending_pixels.pop_front();
			end else begin
				pix_valid <= 1'b0;
			end
		end
	end

	// Receiver: random stalls, or a long hold-off counted here when requested.
	always @(negedge clk) begin
		if (hold_left != 0) begin
			run_stall <= 1'b1;
			hold_left--;
		end else if (hold_request) begin
			hold_request = 1'b0;
			hold_left = HOLD_CYCLES - 1;
			run_stall <= 1'b1;
		end else begin
			run_stall <= !quiet && ($urandom_range(0, 99) < 27);
		end
	end

	task automatic push_pixel(input logic [7:0] px, input logic re, input logic ie);
		trle_pkg::in_beat_t b;
		b.pixel = px;
		b.row_end = re;
		b.image_end = ie;
		pending_pixels.push_back(b);
	endtask

	// Waits until every pixel is taken and every run has come back, then lets
	// the pipeline settle, since a pixel in flight may close no run.
	task automatic wait_idle(input int settle);
		do @(posedge clk);
		while (pending_pixels.size() != 0 || pix_valid || expected_runs.size() != 0);
		repeat (settle) @(posedge clk);
	endtask

	task automatic write_reg(input logic [trle_pkg::CFG_IDX_W-1:0] idx,
			input logic [15:0] value);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
		case (idx)
			trle_pkg::CFG_TRANSPARENCY_KEY: cfg_key = value[7:0];
			trle_pkg::CFG_KEY_FROM_FIRST: cfg_from_first = value[0];
			trle_pkg::CFG_BYTE_LIMIT: cfg_limit = value;
			default: ;
		endcase
		@(posedge clk);
	endtask

	// Queues one image of a few short rows; pixels mostly repeat the key or
	// one other value so that runs form, with some noise in values and marks.
	task automatic queue_image(input logic [7:0] hint, inout int added);
		int rows;
		int width;
		logic [7:0] other;
		trle_pkg::in_beat_t b;
		int pick;
		rows = $urandom_range(1, 4);
		width = $urandom_range(1, 10);
		other = 8'($urandom_range(0, 255));
		for (int r = 0; r < rows; r++) begin
			for (int c = 0; c < width; c++) begin
				pick = $urandom_range(0, 99);
				if (r == 0 && c == 0 && cfg_from_first) b.pixel = hint;
				else if (pick < 45) b.pixel = hint;
				else if (pick < 85) b.pixel = other;
				else b.pixel = 8'($urandom_range(0, 255));
				b.row_end = (c == width - 1);
				b.image_end = (r == rows - 1) && (c == width - 1);
				if (b.image_end && $urandom_range(0, 99) < 10) b.row_end = 1'b0;
				if ($urandom_range(0, 99) < 4) begin
					b.row_end = 1'($urandom_range(0, 1));
					b.image_end = 1'($urandom_range(0, 1));
				end
				pending_pixels.push_back(b);
				added++;
			end
		end
	endtask

	initial begin
		int phase_items;
		logic [15:0] lim;
		logic [7:0] key_val;
		logic mode;
		logic [7:0] px;

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(posedge clk);

		// Image left open, then key taken from the first pixel mid-image:
		// nothing was ever latched, so the key is zero.
		push_pixel(8'd5, 1'b0, 1'b0);
		push_pixel(8'd5, 1'b0, 1'b0);
		wait_idle(DRAIN_CYCLES);
		write_reg(trle_pkg::CFG_KEY_FROM_FIRST, 16'd1);
		push_pixel(8'd0, 1'b1, 1'b0);
		push_pixel(8'd5, 1'b1, 1'b1);
		wait_idle(DRAIN_CYCLES);

		// Fixed key zero: image end without row end, two runs in one pixel.
		write_reg(trle_pkg::CFG_KEY_FROM_FIRST, 16'd0);
		push_pixel(8'd0, 1'b0, 1'b1);
		push_pixel(8'd255, 1'b0, 1'b0);
		push_pixel(8'd255, 1'b1, 1'b0);
		push_pixel(8'd0, 1'b0, 1'b0);
		push_pixel(8'd0, 1'b0, 1'b0);
		push_pixel(8'd128, 1'b1, 1'b1);
		wait_idle(DRAIN_CYCLES);

		// Key latched from each image's first pixel.
		write_reg(trle_pkg::CFG_KEY_FROM_FIRST, 16'd1);
		push_pixel(8'd9, 1'b0, 1'b0);
		push_pixel(8'd9, 1'b0, 1'b0);
		push_pixel(8'd3, 1'b0, 1'b0);
		push_pixel(8'd9, 1'b1, 1'b0);
		push_pixel(8'd200, 1'b0, 1'b0);
		push_pixel(8'd9, 1'b1, 1'b1);
		push_pixel(8'd3, 1'b0, 1'b0);
		push_pixel(8'd9, 1'b0, 1'b0);
		push_pixel(8'd3, 1'b1, 1'b1);
		wait_idle(DRAIN_CYCLES);

		// A limit of two overflows on the first run; later runs are dropped
		// except the final one. Then a limit below two.
		write_reg(trle_pkg::CFG_KEY_FROM_FIRST, 16'd0);
		write_reg(trle_pkg::CFG_TRANSPARENCY_KEY, 16'd255);
		write_reg(trle_pkg::CFG_BYTE_LIMIT, 16'd2);
		push_pixel(8'd255, 1'b0, 1'b0);
		push_pixel(8'd1, 1'b1, 1'b0);
		push_pixel(8'd1, 1'b1, 1'b1);
		wait_idle(DRAIN_CYCLES);
		write_reg(trle_pkg::CFG_BYTE_LIMIT, 16'd1);
		push_pixel(8'd7, 1'b1, 1'b1);
		wait_idle(DRAIN_CYCLES);

		// Random phases, each under its own register setting.
		for (int ph = 0; ph < 8; ph++) begin
			case (ph)
				0: begin key_val = 8'd0; mode = 1'b1; lim = 16'd2; end
				1: begin key_val = 8'd255; mode = 1'b0; lim = 16'd65535; end
				2: begin
					key_val = 8'($urandom_range(0, 255));
					mode = 1'($urandom_range(0, 1));
					lim = 16'd20000;
				end
				3: begin key_val = 8'($urandom_range(0, 255)); mode = 1'b0; lim = 16'd20000; end
				4: begin
					key_val = 8'($urandom_range(0, 255));
					mode = 1'($urandom_range(0, 1));
					lim = 16'($urandom_range(3, 12));
				end
				5: begin
					key_val = 8'($urandom_range(0, 255));
					mode = 1'($urandom_range(0, 1));
					lim = 16'd6;
				end
				6: begin
					key_val = 8'($urandom_range(0, 255));
					mode = 1'($urandom_range(0, 1));
					lim = 16'($urandom_range(13, 60));
				end
				default: begin
					key_val = 8'($urandom_range(0, 255));
					mode = 1'($urandom_range(0, 1));
					lim = 16'($urandom_range(2, 65535));
				end
			endcase
			write_reg(trle_pkg::CFG_TRANSPARENCY_KEY, {8'd0, key_val});
			write_reg(trle_pkg::CFG_KEY_FROM_FIRST, {15'd0, mode});
			write_reg(trle_pkg::CFG_BYTE_LIMIT, lim);

			quiet = (ph == 5);
			steady_sender = (ph == 2);
			if (ph == 2) hold_request = 1'b1;

			phase_items = 0;
			if (ph == 3) begin
				// One row long enough to close a run at the longest length.
				for (int i = 0; i < 256; i++) begin
					do px = 8'($urandom_range(0, 255));
					while (px == cfg_key);
					push_pixel(px, i == 255, i == 255);
				end
			end
			while (phase_items < 40) begin
				queue_image(cfg_from_first ? 8'($urandom_range(0, 255)) : cfg_key, phase_items);
			end
			wait_idle(DRAIN_CYCLES);
			quiet = 1'b0;
			steady_sender = 1'b0;
		end

		wait_idle(DRAIN_CYCLES);
		if (mismatch_count == 0) begin
			$display("tb_transparency_run_length_encoder_top OK");
		end else begin
			$display("tb_transparency_run_length_encoder_top NOT OK");
		end
		$finish;
	end

endmodule

>>> files.f
+incdir+rtl
rtl/trle_pkg.sv
rtl/trle_core.sv
rtl/trle_out_buf.sv
rtl/transparency_run_length_encoder_top.sv
sim/tb_transparency_run_length_encoder_top.sv
